FILE: rtl/quadratic_bezier_connection_sampler_defines.svh
// Assertion macros for the quadratic Bezier connection sampler.
// Used by the top level only; relies on i_clk and i_rst_n in the including scope.
`ifndef QUADRATIC_BEZIER_CONNECTION_SAMPLER_DEFINES_SVH
`define QUADRATIC_BEZIER_CONNECTION_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define QBCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define QBCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/qbcs_pkg.sv
// Shared types and constants of the quadratic Bezier connection sampler.
// No dependencies; used by qbcs_unit_vec and the top level.
package qbcs_pkg;

    // One connection request.
    typedef struct packed {
        logic signed [31:0] from_start_x;
        logic signed [31:0] from_start_y;
        logic signed [31:0] from_start_z;
        logic signed [31:0] from_end_x;
        logic signed [31:0] from_end_y;
        logic signed [31:0] from_end_z;
        logic signed [31:0] to_start_x;
        logic signed [31:0] to_start_y;
        logic signed [31:0] to_start_z;
        logic signed [31:0] forward_offset;
        logic signed [31:0] side_offset;
        logic        [15:0] segment_id;
    } t_req;

    // One emitted curve point.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic        [15:0] point_segment;
        logic        [4:0]  point_index;
        logic               last_point;
    } t_pt;

    // Direction vector components (difference of two 32-bit points).
    typedef logic signed [32:0] t_dcomp;
    typedef t_dcomp [2:0] t_dvec;

    // Unit vector components, signed Q1.16.
    typedef logic signed [17:0] t_ucomp;
    typedef t_ucomp [2:0] t_uvec;

    // Register stages through qbcs_unit_vec.
    localparam int UV_LAT = 55;

endpackage

FILE: rtl/quadratic_bezier_connection_sampler.sv
// Quadratic Bezier connection sampler, top level; uses qbcs_pkg and qbcs_unit_vec.
// Each accepted request passes the entry stage, the unit-vector pipelines, the offset
// stages, the sampler and the evaluation pipeline; points then come one per cycle while
// the output is not stalled, SAMPLES points per request. The rate is set by the single
// point-emitting sampler register feeding the evaluation pipeline.
// Synchronous active-low reset clears all valid bits.
`include "quadratic_bezier_connection_sampler_defines.svh"
module quadratic_bezier_connection_sampler #(
    parameter int SAMPLES = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  qbcs_pkg::t_req i_req,
    output logic           o_pt_valid,
    input  logic           i_pt_stall,
    output qbcs_pkg::t_pt  o_pt
);
    import qbcs_pkg::*;

    localparam int D      = SAMPLES * SAMPLES;
    localparam int KW     = $clog2(SAMPLES);
    localparam int WW     = $clog2(D + 1);
    localparam int PW     = WW + 35;
    localparam int NW     = WW + 37;
    localparam int RW     = WW + 31;
    localparam int DQ_ST  = 4;
    localparam int RSH    = WW + 32;
    localparam logic [KW-1:0] K_LAST   = KW'(SAMPLES - 1);
    localparam logic [NW-1:0] HALF     = NW'(D / 2);
    localparam logic [NW-1:0] SAT_LIM  = NW'(D) << 31;
    localparam logic [RW-1:0] DEN      = RW'(D);
    localparam logic [RW-1:0] DEN2     = RW'(2 * D);
    localparam logic [RW-1:0] DEN3     = RW'(3 * D);
    // Reciprocal of N^2, rounded down, scaled by 2^RSH.
    localparam logic [32:0]   RECIP    = 33'(((64'd1 << RSH) - 64'd1) / 64'(D));

    typedef logic signed [31:0] t_c32;
    typedef logic signed [33:0] t_c34;

    typedef struct packed {
        t_c32 [2:0]  p0;
        t_c32 [2:0]  p2;
        t_c32        fwd;
        t_c32        side;
        logic [15:0] seg;
    } t_side;

    typedef struct packed {
        logic [KW-1:0] k;
        logic          last;
        logic [15:0]   seg;
    } t_meta;

    // Round a Q.24 product to Q.8, half away from zero.
    function automatic t_c34 rnd16(input logic signed [49:0] x);
        logic [49:0] v_mag;
        logic [49:0] v_q;
        v_mag = x[49] ? 50'(-x) : 50'(x);
        v_q   = (v_mag + 50'd32768) >> 16;
        return x[49] ? -$signed(v_q[33:0]) : $signed(v_q[33:0]);
    endfunction

    logic        w_adv, w_front_adv, w_load;

    logic        r_f0_valid;
    t_dvec       r_f0_d, r_f0_nv, n_f0_d, n_f0_nv;
    t_side       r_f0_side, n_f0_side;
    logic [UV_LAT-1:0] r_sl_v;
    t_side       r_sl [0:UV_LAT-1];
    t_uvec       w_u, w_n;

    logic               r_t1_valid, r_t2_valid, r_t3_valid;
    t_side              r_t1_side, r_t2_side, r_t3_side;
    logic signed [49:0] r_t1_pu [0:2];
    logic signed [49:0] r_t1_pn [0:1];
    t_c34               r_t2_ru [0:2];
    t_c34               r_t2_rn [0:1];
    t_c34               r_t3_p1 [0:2];

    logic          r_busy;
    logic [KW-1:0] r_k;
    t_c34          r_sp [0:2][0:2];
    logic [15:0]   r_sseg;

    logic          r_e0_valid, r_e1_valid, r_e2_valid;
    t_meta         r_e0_meta, r_e1_meta, r_e2_meta;
    logic [WW-1:0] r_e0_w [0:2];
    logic [WW-1:0] n_e0_w [0:2];
    t_c34          r_e0_p [0:2][0:2];
    logic signed [PW-1:0] r_e1_pr [0:2][0:2];
    logic signed [PW-1:0] n_e1_pr [0:2][0:2];
    logic signed [NW-1:0] r_e2_num [0:2];
    logic signed [NW-1:0] n_e2_num [0:2];

    logic [DQ_ST:0]  r_dq_v;
    t_meta           r_dq_meta [0:DQ_ST];
    logic [2:0]      r_dq_neg  [0:DQ_ST];
    logic [RW-1:0]   n_dq_rem0 [0:2];
    logic [2:0]      n_dq_neg0;
    logic [RW-1:0]   r_dq0_x   [0:2];
    logic [RW-1:0]   r_dq1_x   [0:2];
    logic [31:0]     r_dq1_q0  [0:2];
    logic [RW-1:0]   r_dq2_x   [0:2];
    logic [31:0]     r_dq2_q0  [0:2];
    logic [RW-1:0]   r_dq2_qd  [0:2];
    logic [RW-1:0]   r_dq3_rem [0:2];
    logic [31:0]     r_dq3_q0  [0:2];
    logic [31:0]     r_dq4_q   [0:2];
    logic [31:0]     n_dq4_q   [0:2];

    logic  r_out_valid;
    t_pt   r_out, n_out;

    // Flow control: the back end moves unless the output is held; the front end
    // also waits while its last stage cannot hand over to the sampler.
    assign w_adv       = !r_out_valid || !i_pt_stall;
    assign w_load      = w_adv && r_t3_valid && (!r_busy || (r_k == K_LAST));
    assign w_front_adv = w_adv && !(r_t3_valid && !w_load);
    assign o_req_stall = !w_front_adv;

    // Entry stage: direction, horizontal normal input and side data.
    always_comb begin
        n_f0_d[0]  = {i_req.from_end_x[31], i_req.from_end_x}
                   - {i_req.from_start_x[31], i_req.from_start_x};
        n_f0_d[1]  = {i_req.from_end_y[31], i_req.from_end_y}
                   - {i_req.from_start_y[31], i_req.from_start_y};
        n_f0_d[2]  = {i_req.from_end_z[31], i_req.from_end_z}
                   - {i_req.from_start_z[31], i_req.from_start_z};
        n_f0_nv[0] = {i_req.from_start_y[31], i_req.from_start_y}
                   - {i_req.from_end_y[31], i_req.from_end_y};
        n_f0_nv[1] = n_f0_d[0];
        n_f0_nv[2] = '0;
        n_f0_side.p0[0] = i_req.from_end_x;
        n_f0_side.p0[1] = i_req.from_end_y;
        n_f0_side.p0[2] = i_req.from_end_z;
        n_f0_side.p2[0] = i_req.to_start_x;
        n_f0_side.p2[1] = i_req.to_start_y;
        n_f0_side.p2[2] = i_req.to_start_z;
        n_f0_side.fwd   = i_req.forward_offset;
        n_f0_side.side  = i_req.side_offset;
        n_f0_side.seg   = i_req.segment_id;
    end

    // Front-end valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_valid <= 1'b0;
            r_sl_v     <= '0;
            r_t1_valid <= 1'b0;
            r_t2_valid <= 1'b0;
            r_t3_valid <= 1'b0;
        end else if (w_front_adv) begin
            r_f0_valid <= i_req_valid;
            r_sl_v     <= {r_sl_v[UV_LAT-2:0], r_f0_valid};
            r_t1_valid <= r_sl_v[UV_LAT-1];
            r_t2_valid <= r_t1_valid;
            r_t3_valid <= r_t2_valid;
        end
    end

    // Front-end payload: side data rides alongside the unit-vector pipelines.
    always_ff @(posedge i_clk) begin
        if (w_front_adv) begin
            r_f0_d    <= n_f0_d;
            r_f0_nv   <= n_f0_nv;
            r_f0_side <= n_f0_side;
            r_sl[0]   <= r_f0_side;
            for (int j = 1; j < UV_LAT; j++) begin
                r_sl[j] <= r_sl[j-1];
            end
            // Offset products.
            r_t1_side <= r_sl[UV_LAT-1];
            for (int i = 0; i < 3; i++) begin
                r_t1_pu[i] <= $signed(w_u[i]) * $signed(r_sl[UV_LAT-1].fwd);
            end
            for (int i = 0; i < 2; i++) begin
                r_t1_pn[i] <= $signed(w_n[i]) * $signed(r_sl[UV_LAT-1].side);
            end
            // Back to Q.8.
            r_t2_side <= r_t1_side;
            for (int i = 0; i < 3; i++) begin
                r_t2_ru[i] <= rnd16(r_t1_pu[i]);
            end
            for (int i = 0; i < 2; i++) begin
                r_t2_rn[i] <= rnd16(r_t1_pn[i]);
            end
            // Middle control point at full width.
            r_t3_side <= r_t2_side;
            for (int i = 0; i < 3; i++) begin
                r_t3_p1[i] <= 34'($signed(r_t2_side.p0[i])) + r_t2_ru[i]
                            + ((i < 2) ? r_t2_rn[i % 2] : 34'sd0);
            end
        end
    end

    qbcs_unit_vec u_dir (
        .i_clk (i_clk),
        .i_en  (w_front_adv),
        .i_d   (r_f0_d),
        .o_u   (w_u)
    );

    qbcs_unit_vec u_nrm (
        .i_clk (i_clk),
        .i_en  (w_front_adv),
        .i_d   (r_f0_nv),
        .o_u   (w_n)
    );

    // Sampler: holds one request and issues sample numbers in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (w_adv) begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy && (r_k == K_LAST)) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int i = 0; i < 3; i++) begin
                r_sp[0][i] <= 34'($signed(r_t3_side.p0[i]));
                r_sp[1][i] <= r_t3_p1[i];
                r_sp[2][i] <= 34'($signed(r_t3_side.p2[i]));
            end
            r_sseg <= r_t3_side.seg;
        end
    end

    // Bernstein weights (N-k)^2, 2k(N-k), k^2 and the weighted terms.
    always_comb begin
        logic [WW-1:0] v_nk;
        v_nk      = WW'(SAMPLES) - WW'(r_k);
        n_e0_w[0] = v_nk * v_nk;
        n_e0_w[1] = (WW'(r_k) * v_nk) << 1;
        n_e0_w[2] = WW'(r_k) * WW'(r_k);
        for (int a = 0; a < 3; a++) begin
            for (int t = 0; t < 3; t++) begin
                n_e1_pr[a][t] = $signed({1'b0, r_e0_w[t]}) * r_e0_p[t][a];
            end
            n_e2_num[a] = NW'(r_e1_pr[a][0]) + NW'(r_e1_pr[a][1]) + NW'(r_e1_pr[a][2]);
        end
    end

    // Magnitude with rounding half, clamped to the largest needed quotient.
    always_comb begin
        logic [NW-1:0] v_mag;
        logic [NW-1:0] v_mh;
        for (int a = 0; a < 3; a++) begin
            n_dq_neg0[a] = r_e2_num[a][NW-1];
            v_mag = r_e2_num[a][NW-1] ? NW'(-r_e2_num[a]) : NW'(r_e2_num[a]);
            v_mh  = v_mag + HALF;
            n_dq_rem0[a] = (v_mh >= SAT_LIM) ? RW'(SAT_LIM) : RW'(v_mh);
        end
    end

    // Division by N^2: the reciprocal estimate is low by at most three, so the
    // remainder picks the final correction.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_dq3_rem[a] >= DEN3) begin
                n_dq4_q[a] = r_dq3_q0[a] + 32'd3;
            end else if (r_dq3_rem[a] >= DEN2) begin
                n_dq4_q[a] = r_dq3_q0[a] + 32'd2;
            end else if (r_dq3_rem[a] >= DEN) begin
                n_dq4_q[a] = r_dq3_q0[a] + 32'd1;
            end else begin
                n_dq4_q[a] = r_dq3_q0[a];
            end
        end
    end

    // Sign and saturation into the output register.
    always_comb begin
        logic [31:0] v_q [0:2];
        logic [31:0] v_r [0:2];
        for (int a = 0; a < 3; a++) begin
            v_q[a] = r_dq4_q[a];
            if (r_dq_neg[DQ_ST][a]) begin
                v_r[a] = -v_q[a];
            end else if (v_q[a][31]) begin
                v_r[a] = 32'h7FFF_FFFF;
            end else begin
                v_r[a] = v_q[a];
            end
        end
        n_out.point_x       = $signed(v_r[0]);
        n_out.point_y       = $signed(v_r[1]);
        n_out.point_z       = $signed(v_r[2]);
        n_out.point_segment = r_dq_meta[DQ_ST].seg;
        n_out.point_index   = 5'(r_dq_meta[DQ_ST].k);
        n_out.last_point    = r_dq_meta[DQ_ST].last;
    end

    // Evaluation pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_valid  <= 1'b0;
            r_e1_valid  <= 1'b0;
            r_e2_valid  <= 1'b0;
            r_dq_v      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_e0_valid  <= r_busy;
            r_e1_valid  <= r_e0_valid;
            r_e2_valid  <= r_e1_valid;
            r_dq_v      <= {r_dq_v[DQ_ST-1:0], r_e2_valid};
            r_out_valid <= r_dq_v[DQ_ST];
        end
    end

    // Evaluation pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e0_meta.k    <= r_k;
            r_e0_meta.last <= (r_k == K_LAST);
            r_e0_meta.seg  <= r_sseg;
            r_e0_w         <= n_e0_w;
            r_e0_p         <= r_sp;
            r_e1_meta      <= r_e0_meta;
            r_e1_pr        <= n_e1_pr;
            r_e2_meta      <= r_e1_meta;
            r_e2_num       <= n_e2_num;
            r_dq_meta[0]   <= r_e2_meta;
            r_dq_neg[0]    <= n_dq_neg0;
            for (int j = 0; j < DQ_ST; j++) begin
                r_dq_meta[j+1] <= r_dq_meta[j];
                r_dq_neg[j+1]  <= r_dq_neg[j];
            end
            // Quotient estimate, its product with N^2, remainder, correction.
            for (int a = 0; a < 3; a++) begin
                r_dq0_x[a]   <= n_dq_rem0[a];
                r_dq1_x[a]   <= r_dq0_x[a];
                r_dq1_q0[a]  <= 32'((64'(r_dq0_x[a][RW-1:WW]) * 64'(RECIP)) >> 32);
                r_dq2_x[a]   <= r_dq1_x[a];
                r_dq2_q0[a]  <= r_dq1_q0[a];
                r_dq2_qd[a]  <= RW'(r_dq1_q0[a]) * DEN;
                r_dq3_rem[a] <= r_dq2_x[a] - r_dq2_qd[a];
                r_dq3_q0[a]  <= r_dq2_q0[a];
                r_dq4_q[a]   <= n_dq4_q[a];
            end
            r_out <= n_out;
        end
    end

    assign o_pt_valid = r_out_valid;
    assign o_pt       = r_out;

    // A finished control point waits until the sampler takes it.
    `QBCS_ASSERT_NEXT(a_front_hold, r_t3_valid && !w_load, r_t3_valid, "request lost at sampler")
    // A run steps through every sample number without gaps.
    `QBCS_ASSERT_NEXT(a_run_step, r_busy && w_adv && (r_k != K_LAST), r_busy && (r_k == KW'($past(r_k) + 1'b1)), "sample number skipped")
    // The last point of a run carries the final sample number.
    `QBCS_ASSERT_NOW(a_last_index, o_pt_valid && o_pt.last_point, o_pt.point_index == 5'(SAMPLES - 1), "last point index wrong")

endmodule

FILE: rtl/qbcs_unit_vec.sv
// Pipelined unit-vector unit: normalize, sum of squares, bit-serial square root
// stages and restoring division stages. Depends on qbcs_pkg.
module qbcs_unit_vec (
    input  logic            i_clk,
    input  logic            i_en,
    input  qbcs_pkg::t_dvec i_d,
    output qbcs_pkg::t_uvec o_u
);
    import qbcs_pkg::*;

    localparam int AW    = 30;
    localparam int SQ_ST = 31;
    localparam int DV_ST = 17;

    typedef struct packed {
        logic [2:0][AW-1:0] a;
        logic [2:0]         neg;
        logic               zero;
    } t_car;

    logic [2:0][32:0]    n_s1_mag, r_s1_mag, r_s2_mag;
    logic [2:0]          n_s1_neg, r_s1_neg, r_s2_neg;
    logic [5:0]          n_s2_top, r_s2_top;
    logic                n_s2_zero, r_s2_zero;
    t_car                n_s3, r_s3, r_s4_car;
    logic [2:0][59:0]    n_s4_sq, r_s4_sq;
    logic [62:0]         n_sq_v0;
    logic [62:0]         r_sq_v   [0:SQ_ST];
    logic [62:0]         r_sq_res [0:SQ_ST];
    t_car                r_sq_car [0:SQ_ST];
    logic [62:0]         n_sq_v   [0:SQ_ST-1];
    logic [62:0]         n_sq_res [0:SQ_ST-1];
    logic [2:0][47:0]    n_dv_rem0;
    logic [2:0][47:0]    r_dv_rem [0:DV_ST];
    logic [2:0][16:0]    r_dv_q   [0:DV_ST];
    logic [30:0]         r_dv_len [0:DV_ST];
    logic [2:0]          r_dv_neg [0:DV_ST];
    logic                r_dv_zero[0:DV_ST];
    logic [2:0][47:0]    n_dv_rem [0:DV_ST-1];
    logic [2:0][16:0]    n_dv_q   [0:DV_ST-1];
    t_uvec               n_u, r_u;

    // Stage 1: magnitudes and signs.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_neg[i] = i_d[i][32];
            n_s1_mag[i] = i_d[i][32] ? 33'(-i_d[i]) : 33'(i_d[i]);
        end
    end

    // Stage 2: position of the leading one over all components.
    always_comb begin
        logic [32:0] v_or;
        v_or      = r_s1_mag[0] | r_s1_mag[1] | r_s1_mag[2];
        n_s2_zero = (v_or == '0);
        n_s2_top  = '0;
        for (int b = 0; b < 33; b++) begin
            if (v_or[b]) begin
                n_s2_top = 6'(b);
            end
        end
    end

    // Stage 3: shift so that the largest magnitude sits in [2^29, 2^30).
    always_comb begin
        logic [32:0] v_sh;
        for (int i = 0; i < 3; i++) begin
            if (r_s2_top >= 6'd29) begin
                v_sh = r_s2_mag[i] >> (r_s2_top - 6'd29);
            end else begin
                v_sh = r_s2_mag[i] << (6'd29 - r_s2_top);
            end
            n_s3.a[i] = v_sh[AW-1:0];
        end
        n_s3.neg  = r_s2_neg;
        n_s3.zero = r_s2_zero;
    end

    // Stage 4 squares, stage 5 their sum.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s4_sq[i] = r_s3.a[i] * r_s3.a[i];
        end
        n_sq_v0 = 63'(r_s4_sq[0]) + 63'(r_s4_sq[1]) + 63'(r_s4_sq[2]);
    end

    // Square root, one result bit per stage.
    always_comb begin
        logic [62:0] v_bit;
        logic [62:0] v_t;
        for (int j = 0; j < SQ_ST; j++) begin
            v_bit = 63'(1) << (60 - 2 * j);
            v_t   = r_sq_res[j] + v_bit;
            if (r_sq_v[j] >= v_t) begin
                n_sq_v[j]   = r_sq_v[j] - v_t;
                n_sq_res[j] = (r_sq_res[j] >> 1) + v_bit;
            end else begin
                n_sq_v[j]   = r_sq_v[j];
                n_sq_res[j] = r_sq_res[j] >> 1;
            end
        end
    end

    // Rounded dividend for each component: a * 2^16 + len / 2.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_dv_rem0[i] = {2'b00, r_sq_car[SQ_ST].a[i], 16'h0000}
                         + 48'(r_sq_res[SQ_ST][30:1]);
        end
    end

    // Restoring division, one quotient bit per stage.
    always_comb begin
        logic [47:0] v_ds;
        for (int j = 0; j < DV_ST; j++) begin
            v_ds = 48'(r_dv_len[j]) << (DV_ST - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (r_dv_rem[j][i] >= v_ds) begin
                    n_dv_rem[j][i] = r_dv_rem[j][i] - v_ds;
                    n_dv_q[j][i]   = r_dv_q[j][i] | (17'(1) << (DV_ST - 1 - j));
                end else begin
                    n_dv_rem[j][i] = r_dv_rem[j][i];
                    n_dv_q[j][i]   = r_dv_q[j][i];
                end
            end
        end
    end

    // Sign restore; a zero vector stays zero.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_zero[DV_ST]) begin
                n_u[i] = '0;
            end else if (r_dv_neg[DV_ST][i]) begin
                n_u[i] = -$signed({1'b0, r_dv_q[DV_ST][i]});
            end else begin
                n_u[i] = $signed({1'b0, r_dv_q[DV_ST][i]});
            end
        end
    end

    // Pipeline registers, all advancing together.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mag  <= n_s1_mag;
            r_s1_neg  <= n_s1_neg;
            r_s2_mag  <= r_s1_mag;
            r_s2_neg  <= r_s1_neg;
            r_s2_top  <= n_s2_top;
            r_s2_zero <= n_s2_zero;
            r_s3      <= n_s3;
            r_s4_sq   <= n_s4_sq;
            r_s4_car  <= r_s3;
            r_sq_v[0]   <= n_sq_v0;
            r_sq_res[0] <= '0;
            r_sq_car[0] <= r_s4_car;
            for (int j = 0; j < SQ_ST; j++) begin
                r_sq_v[j+1]   <= n_sq_v[j];
                r_sq_res[j+1] <= n_sq_res[j];
                r_sq_car[j+1] <= r_sq_car[j];
            end
            r_dv_rem[0]  <= n_dv_rem0;
            r_dv_q[0]    <= '0;
            r_dv_len[0]  <= r_sq_res[SQ_ST][30:0];
            r_dv_neg[0]  <= r_sq_car[SQ_ST].neg;
            r_dv_zero[0] <= r_sq_car[SQ_ST].zero;
            for (int j = 0; j < DV_ST; j++) begin
                r_dv_rem[j+1]  <= n_dv_rem[j];
                r_dv_q[j+1]    <= n_dv_q[j];
                r_dv_len[j+1]  <= r_dv_len[j];
                r_dv_neg[j+1]  <= r_dv_neg[j];
                r_dv_zero[j+1] <= r_dv_zero[j];
            end
            r_u <= n_u;
        end
    end

    assign o_u = r_u;

endmodule

FILE: verif/quadratic_bezier_connection_sampler_test.sv
// Self-checking testbench for the quadratic Bezier connection sampler.
// Depends on qbcs_pkg and the quadratic_bezier_connection_sampler top level.
`timescale 1ns / 100ps
module quadratic_bezier_connection_sampler_test;
    import qbcs_pkg::*;

    localparam int NPTS = 20;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_stall;
    t_req i_req = '0;
    logic o_pt_valid;
    logic i_pt_stall = 1'b0;
    t_pt  o_pt;

    t_pt  curve_points_due[$];
    int   mismatch_count = 0;
    int   requests_sent = 0;
    int   points_seen = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    quadratic_bezier_connection_sampler #(.SAMPLES(NPTS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_stall(o_req_stall), .i_req(i_req),
        .o_pt_valid(o_pt_valid), .i_pt_stall(i_pt_stall), .o_pt(o_pt)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle counter with a hard timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver stall, randomized per cycle.
    always @(posedge i_clk) begin
        i_pt_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [63:0] abs_of(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Division rounding half away from zero.
    function automatic logic signed [63:0] div_round(input logic signed [63:0] num,
                                                     input logic [63:0] den);
        logic [63:0] q;
        q = (abs_of(num) + den / 2) / den;
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Normalize a 2D or 3D vector to signed Q1.16.
    task automatic normalize(input logic signed [63:0] d [3], input int n,
                             output logic signed [63:0] u [3]);
        logic [63:0] a [3];
        logic [63:0] m;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            u[i] = 0;
            a[i] = (i < n) ? abs_of(d[i]) : 0;
            if (a[i] > m) m = a[i];
        end
        if (m == 0) return;
        while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
        end
        while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
        end
        for (int i = 0; i < n; i++) sum = sum + a[i] * a[i];
        len = floor_sqrt(sum);
        for (int i = 0; i < n; i++) begin
            q = (a[i] * 64'd65536 + len / 2) / len;
            u[i] = d[i] < 0 ? -$signed(q) : $signed(q);
        end
    endtask

    // Compute the expected curve points of one request.
    task automatic predict_curve(input t_req r);
        logic signed [63:0] p0 [3];
        logic signed [63:0] p1 [3];
        logic signed [63:0] p2 [3];
        logic signed [63:0] d [3];
        logic signed [63:0] u [3];
        logic signed [63:0] nv [3];
        logic signed [63:0] nn [3];
        logic signed [63:0] fwd;
        logic signed [63:0] side;
        logic signed [63:0] ca, cb, cc, num, v;
        t_pt pt;
        p0[0] = r.from_end_x; p0[1] = r.from_end_y; p0[2] = r.from_end_z;
        p2[0] = r.to_start_x; p2[1] = r.to_start_y; p2[2] = r.to_start_z;
        d[0] = p0[0] - 64'(r.from_start_x);
        d[1] = p0[1] - 64'(r.from_start_y);
        d[2] = p0[2] - 64'(r.from_start_z);
        fwd = r.forward_offset;
        side = r.side_offset;
        normalize(d, 3, u);
        nv[0] = -d[1]; nv[1] = d[0]; nv[2] = 0;
        normalize(nv, 2, nn);
        for (int i = 0; i < 3; i++)
            p1[i] = p0[i] + div_round(u[i] * fwd, 65536)
                    + ((i < 2) ? div_round(nn[i] * side, 65536) : 64'sd0);
        for (int k = 0; k < NPTS; k++) begin
            ca = (NPTS - k) * (NPTS - k);
            cb = 2 * k * (NPTS - k);
            cc = k * k;
            for (int i = 0; i < 3; i++) begin
                num = ca * p0[i] + cb * p1[i] + cc * p2[i];
                v = div_round(num, NPTS * NPTS);
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                if (i == 0) pt.point_x = v[31:0];
                else if (i == 1) pt.point_y = v[31:0];
                else pt.point_z = v[31:0];
            end
            pt.point_segment = r.segment_id;
            pt.point_index = k[4:0];
            pt.last_point = (k == NPTS - 1);
            curve_points_due.push_back(pt);
        end
    endtask

    // Check each accepted point against the oldest expected one.
    always @(posedge i_clk) begin
        t_pt exp_pt;
        if (i_rst_n && o_pt_valid && !i_pt_stall) begin
            points_seen <= points_seen + 1;
            if (curve_points_due.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("Unexpected point: %p", o_pt);
            end else begin
                exp_pt = curve_points_due.pop_front();
                if (o_pt !== exp_pt) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("Point mismatch: expected %p, got %p", exp_pt, o_pt);
                end
            end
        end
    end

    // Present one request and hold it until it is accepted; valid drops only
    // while the sender idles or the phase drains.
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_curve(r);
        i_req_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(20000)) - 10000;
            2: return $signed($urandom_range(2000000)) - 1000000;
            default: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
        endcase
    endfunction

    function automatic t_req rand_request();
        t_req r;
        r.from_start_x = rand_coord(); r.from_start_y = rand_coord();
        r.from_start_z = rand_coord();
        r.from_end_x = rand_coord(); r.from_end_y = rand_coord();
        r.from_end_z = rand_coord();
        r.to_start_x = rand_coord(); r.to_start_y = rand_coord();
        r.to_start_z = rand_coord();
        r.forward_offset = rand_coord(); r.side_offset = rand_coord();
        r.segment_id = 16'($urandom);
        // Sometimes force a vertical or zero incoming direction.
        if ($urandom_range(9) == 0) begin
            r.from_start_x = r.from_end_x;
            r.from_start_y = r.from_end_y;
            if ($urandom_range(1)) r.from_start_z = r.from_end_z;
        end
        return r;
    endfunction

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (curve_points_due.size() != 0) @(posedge i_clk);
    endtask

    // Directed cases: extremes, zero and vertical directions, saturation.
    task automatic test_directed();
        t_req r;
        logic [31:0] vals [4];
        vals[0] = 32'h8000_0000; vals[1] = 32'h7FFF_FFFF; vals[2] = 0;
        vals[3] = 32'hFFFF_FFFF;
        r = '0;
        send_request(r);
        for (int j = 0; j < 4; j++) begin
            r = {{11{vals[j]}}, 16'(j * 4369)};
            send_request(r);
        end
        // Incoming direction straight up: no horizontal normal.
        r = '0;
        r.from_start_z = -32'sd2560; r.forward_offset = 32'sd1280;
        r.side_offset = 32'sd768; r.to_start_x = 32'sd5120; r.segment_id = 16'hFFFF;
        send_request(r);
        // Opposite corners to drive saturation both ways.
        r = '0;
        r.from_start_x = 32'h8000_0000; r.from_end_x = 32'h7FFF_FFFF;
        r.from_start_y = 32'h7FFF_FFFF; r.from_end_y = 32'h8000_0000;
        r.forward_offset = 32'h7FFF_FFFF; r.side_offset = 32'h8000_0000;
        r.to_start_x = 32'h7FFF_FFFF; r.to_start_y = 32'h8000_0000;
        send_request(r);
        r.forward_offset = 32'h8000_0000; r.side_offset = 32'h7FFF_FFFF;
        send_request(r);
        for (int j = 0; j < 12; j++) send_request(rand_request());
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int j = 0; j < count; j++) send_request(rand_request());
        // Hold off until every point has come out, then continue.
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(35, 0, 0);
        test_random(35, 54, 0);
        test_random(35, 0, 54);
        test_random(35, 35, 35);
        repeat (150) @(posedge i_clk);
        $display("Sent %0d requests, checked %0d curve points under varied idling.",
                 requests_sent, points_seen);
        if (mismatch_count == 0 && curve_points_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d points missing", mismatch_count,
                     curve_points_due.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
